// ----- hdl/http_header_length_scanner_assert.svh -----
// Assertion macros for the HTTP header length scanner.
// Used by the top level; expects clk and rst_n in scope where expanded.
`ifndef HTTP_HEADER_LENGTH_SCANNER_ASSERT_SVH
`define HTTP_HEADER_LENGTH_SCANNER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define HHLS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hhls assertion failed");

// next-cycle implication, disabled during reset
`define HHLS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hhls assertion failed");

`endif

// ----- hdl/hhls_pkg.sv -----
// Package for the HTTP header length scanner: word types, codes, byte classifier.
// No dependencies; imported by the top level, the front end and the back end.
package hhls_pkg;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_INCOMPLETE = 2'd1,
        ST_INVALID    = 2'd2,
        ST_TOO_LONG   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_REQ   = 2'd0,
        PH_NAME  = 2'd1,
        PH_REST  = 2'd2,
        PH_VALUE = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        VP_SKIP   = 3'd0,
        VP_WS     = 3'd1,
        VP_SIGN   = 3'd2,
        VP_DIGITS = 3'd3,
        VP_BAD    = 3'd4
    } vphase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] header_size;
        logic [30:0] content_length;
    } result_t;

    typedef struct packed {
        logic nul;
        logic cr;
        logic lf;
        logic colon;
        logic sp_tab;
        logic ws;
        logic sign;
        logic minus;
        logic digit;
    } cls_t;

    // classified word passed from front to back
    typedef struct packed {
        cls_t       cls;
        logic [7:0] lc;
        logic       last;
    } mid_t;

    localparam logic [7:0]  CHAR_CR        = 8'h0d;
    localparam int          KEY_LEN        = 14;
    localparam logic [31:0] SAT_VALUE      = 32'h8000_0000;
    localparam logic [30:0] MAX_BODY_RESET = 31'd1048576;

    function automatic cls_t classify(logic [7:0] b);
        cls_t c;
        c.nul    = (b == 8'h00);
        c.cr     = (b == 8'h0d);
        c.lf     = (b == 8'h0a);
        c.colon  = (b == 8'h3a);
        c.sp_tab = (b == 8'h20) || (b == 8'h09);
        c.ws     = c.sp_tab || (b == 8'h0a) || (b == 8'h0b) || (b == 8'h0c) || (b == 8'h0d);
        c.sign   = (b == 8'h2b) || (b == 8'h2d);
        c.minus  = (b == 8'h2d);
        c.digit  = (b >= 8'h30) && (b <= 8'h39);
        return c;
    endfunction

    // "content-length", lower case
    function automatic logic [7:0] key_at(logic [3:0] pos);
        logic [7:0] k;
        case (pos)
            4'd0:    k = 8'h63;
            4'd1:    k = 8'h6f;
            4'd2:    k = 8'h6e;
            4'd3:    k = 8'h74;
            4'd4:    k = 8'h65;
            4'd5:    k = 8'h6e;
            4'd6:    k = 8'h74;
            4'd7:    k = 8'h2d;
            4'd8:    k = 8'h6c;
            4'd9:    k = 8'h65;
            4'd10:   k = 8'h6e;
            4'd11:   k = 8'h67;
            4'd12:   k = 8'h74;
            4'd13:   k = 8'h68;
            default: k = 8'h00;
        endcase
        return k;
    endfunction

endpackage

// ----- hdl/http_header_length_scanner.sv -----
// HTTP header length scanner: one byte per cycle sustained unless the result queue is full.
// A pushed byte is queued, then taken from the queue head into the scan state register; a result
// word from a last byte enters the result queue with that update (two-entry queues on both sides).
// Reset (rst_n low, asynchronous): queues empty, scan restarts at the request line,
// max_body returns to 1048576. No clearing pass.
// Depends on hhls_pkg, hhls_front, hhls_scan, hhls_fifo and the assertion macro header.
`include "http_header_length_scanner_assert.svh"

module http_header_length_scanner #(
    parameter int MAX_HEADER_BYTES   = 65535,
    parameter int VALUE_BUFFER_BYTES = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  hhls_pkg::item_t   item,
    input  logic              pop,
    output logic              empty,
    output hhls_pkg::result_t result,
    input  logic              cfg_wen,
    input  logic [30:0]       cfg_data
);
    import hhls_pkg::*;

    mid_t    mid_word;
    logic    mid_empty, mid_pop;
    logic    out_full, out_push;
    result_t out_word;
    logic [$bits(result_t)-1:0] out_bits;
    logic    fail_word;
    logic    fields_zero;

    hhls_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .mid_pop   (mid_pop),
        .mid_word  (mid_word),
        .mid_empty (mid_empty)
    );

    hhls_scan #(
        .MAX_HEADER_BYTES   (MAX_HEADER_BYTES),
        .VALUE_BUFFER_BYTES (VALUE_BUFFER_BYTES)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_data  (cfg_data),
        .mid_empty (mid_empty),
        .mid_word  (mid_word),
        .mid_pop   (mid_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_word  (out_word)
    );

    hhls_fifo #(
        .WIDTH($bits(result_t)),
        .DEPTH(2)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_word),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_bits),
        .empty (empty)
    );

    assign result = result_t'(out_bits);

    assign fail_word   = !empty && (result.status != ST_OK);
    assign fields_zero = (result.header_size == '0) && (result.content_length == '0);

    `HHLS_ASSERT_IMP(a_out_no_overflow, out_push, !out_full)
    `HHLS_ASSERT_IMP(a_fail_zero_fields, fail_word, fields_zero)
    `HHLS_ASSERT_NXT(a_result_visible, out_push && empty, !empty)

endmodule

// ----- hdl/hhls_fifo.sv -----
// Small register queue, generic width and depth.
// No dependencies; used between front and back and on the result side.
module hhls_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- hdl/hhls_front.sv -----
// Front end: takes request bytes, classifies them and queues the classified words.
// Depends on hhls_pkg and hhls_fifo.
module hhls_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hhls_pkg::item_t item,
    output logic           full,
    input  logic           mid_pop,
    output hhls_pkg::mid_t mid_word,
    output logic           mid_empty
);
    import hhls_pkg::*;

    mid_t            cls_word;
    logic [7:0]      b;
    logic [$bits(mid_t)-1:0] rd_bits;

    assign b = item.data_byte;

    always_comb
    begin
        cls_word.cls  = classify(b);
        cls_word.lc   = ((b >= 8'h41) && (b <= 8'h5a)) ? (b + 8'd32) : b;
        cls_word.last = item.last;
    end

    hhls_fifo #(
        .WIDTH($bits(mid_t)),
        .DEPTH(2)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cls_word),
        .full  (full),
        .pop   (mid_pop),
        .rdata (rd_bits),
        .empty (mid_empty)
    );

    assign mid_word = mid_t'(rd_bits);

endmodule

// ----- hdl/hhls_scan.sv -----
// Back end: per-byte header scanner state, Content-Length parse, result build.
// Depends on hhls_pkg.
module hhls_scan #(
    parameter int MAX_HEADER_BYTES   = 65535,
    parameter int VALUE_BUFFER_BYTES = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wen,
    input  logic [30:0]       cfg_data,
    input  logic              mid_empty,
    input  hhls_pkg::mid_t    mid_word,
    output logic              mid_pop,
    input  logic              out_full,
    output logic              out_push,
    output hhls_pkg::result_t out_word
);
    import hhls_pkg::*;

    localparam int CW = $clog2(MAX_HEADER_BYTES + 1);
    localparam int VW = $clog2(VALUE_BUFFER_BYTES);

    typedef struct packed {
        vphase_t       vp;
        logic [VW-1:0] vl;
        logic [31:0]   acc;
        logic          neg;
    } val_t;

    typedef struct packed {
        phase_t        ph;
        logic          first;
        logic          cr;
        logic          emp;
        logic [3:0]    pos;
        logic          mis;
        val_t          v;
        logic          fnd;
        logic          inv;
        logic          dn;
        status_t       oc;
        logic [30:0]   acl;
        logic [CW-1:0] cnt;
    } scan_t;

    function automatic scan_t scan_init();
        scan_t r;
        r.ph    = PH_REQ;
        r.first = 1'b0;
        r.cr    = 1'b0;
        r.emp   = 1'b1;
        r.pos   = '0;
        r.mis   = 1'b0;
        r.v.vp  = VP_SKIP;
        r.v.vl  = '0;
        r.v.acc = '0;
        r.v.neg = 1'b0;
        r.fnd   = 1'b0;
        r.inv   = 1'b0;
        r.dn    = 1'b0;
        r.oc    = ST_OK;
        r.acl   = '0;
        r.cnt   = '0;
        return r;
    endfunction

    // acc*10 + d, saturating at 2^31
    function automatic logic [31:0] add_digit(logic [31:0] acc, logic [3:0] d);
        logic [35:0] t;
        t = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'b0, d};
        if (t > {4'b0, SAT_VALUE})
        begin
            return SAT_VALUE;
        end
        return t[31:0];
    endfunction

    function automatic val_t val_char(val_t v, cls_t c, logic [3:0] d);
        val_t r;
        logic go;
        r  = v;
        go = 1'b1;
        if (r.vp == VP_SKIP)
        begin
            if (c.sp_tab)
            begin
                go = 1'b0;
            end
            else
            begin
                r.vp = VP_WS;
            end
        end
        if (go && (r.vp != VP_BAD))
        begin
            if (r.vl >= VW'(VALUE_BUFFER_BYTES - 1))
            begin
                r.vp = VP_BAD;
            end
            else
            begin
                r.vl = r.vl + 1'b1;
                if (r.vp == VP_WS)
                begin
                    if (!c.ws)
                    begin
                        if (c.sign)
                        begin
                            r.neg = c.minus;
                            r.vp  = VP_SIGN;
                        end
                        else if (c.digit)
                        begin
                            r.acc = add_digit(r.acc, d);
                            r.vp  = VP_DIGITS;
                        end
                        else
                        begin
                            r.vp = VP_BAD;
                        end
                    end
                end
                else if (c.digit)
                begin
                    r.acc = add_digit(r.acc, d);
                    r.vp  = VP_DIGITS;
                end
                else
                begin
                    r.vp = VP_BAD;
                end
            end
        end
        return r;
    endfunction

    // one content byte of a line
    function automatic scan_t feed(scan_t s, cls_t c, logic [7:0] lc);
        scan_t r;
        r     = s;
        r.emp = 1'b0;
        case (r.ph)
            PH_NAME:
            begin
                if (c.colon)
                begin
                    if (!r.mis && (r.pos == 4'(KEY_LEN)) && !r.fnd)
                    begin
                        r.ph    = PH_VALUE;
                        r.v.vp  = VP_SKIP;
                        r.v.vl  = '0;
                        r.v.acc = '0;
                        r.v.neg = 1'b0;
                        r.fnd   = 1'b1;
                    end
                    else
                    begin
                        r.ph = PH_REST;
                    end
                end
                else if ((r.pos < 4'(KEY_LEN)) && (lc == key_at(r.pos)))
                begin
                    r.pos = r.pos + 1'b1;
                end
                else
                begin
                    r.mis = 1'b1;
                end
            end
            PH_VALUE:
            begin
                r.v = val_char(r.v, c, lc[3:0]);
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic scan_t line_end(scan_t s, logic [30:0] mb);
        scan_t r;
        r = s;
        if ((r.ph != PH_REQ) && r.emp)
        begin
            // blank line: header block complete
            r.dn = 1'b1;
            if (r.first)
            begin
                r.inv = 1'b1;
            end
            r.oc = r.inv ? ST_INVALID : ST_OK;
        end
        else
        begin
            if (r.ph == PH_VALUE)
            begin
                if ((r.v.vp == VP_DIGITS) && !(r.v.neg && (r.v.acc != '0))
                    && (r.v.acc <= {1'b0, mb}))
                begin
                    r.acl = r.v.acc[30:0];
                end
                else
                begin
                    r.inv = 1'b1;
                end
            end
            r.first = (r.ph == PH_REQ);
            r.ph    = PH_NAME;
            r.pos   = '0;
            r.mis   = 1'b0;
            r.emp   = 1'b1;
        end
        return r;
    endfunction

    scan_t       s_reg, s_next, u;
    logic [30:0] max_body_reg;
    logic        take;
    logic        lend;
    logic [CW+15:0] cnt_ext;
    logic        ok;

    assign take     = !mid_empty && (!mid_word.last || !out_full);
    assign mid_pop  = take;
    assign out_push = take && mid_word.last;

    // state update for the word at the head of the queue
    always_comb
    begin
        u    = s_reg;
        lend = 1'b0;
        if (!s_reg.dn)
        begin
            if (mid_word.cls.nul)
            begin
                u.dn = 1'b1;
                u.oc = ST_INCOMPLETE;
            end
            else
            begin
                u.cnt = s_reg.cnt + 1'b1;
                if (u.cr)
                begin
                    u.cr = 1'b0;
                    if (mid_word.cls.lf)
                    begin
                        lend = 1'b1;
                    end
                    else
                    begin
                        // lone CR is line content
                        u = feed(u, classify(CHAR_CR), CHAR_CR);
                    end
                end
                if (lend)
                begin
                    u = line_end(u, max_body_reg);
                end
                else if (mid_word.cls.cr)
                begin
                    u.cr = 1'b1;
                end
                else
                begin
                    u = feed(u, mid_word.cls, mid_word.lc);
                end
                if (!u.dn && (u.cnt >= CW'(MAX_HEADER_BYTES)))
                begin
                    u.dn = 1'b1;
                    u.oc = ST_TOO_LONG;
                end
            end
        end
    end

    always_comb
    begin
        s_next = s_reg;
        if (take)
        begin
            s_next = mid_word.last ? scan_init() : u;
        end
    end

    // result word
    always_comb
    begin
        cnt_ext                 = {16'b0, u.cnt};
        out_word.status         = u.dn ? u.oc : ST_INCOMPLETE;
        ok                      = (out_word.status == ST_OK);
        out_word.header_size    = ok ? cnt_ext[15:0] : '0;
        out_word.content_length = ok ? u.acl : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg        <= scan_init();
            max_body_reg <= MAX_BODY_RESET;
        end
        else
        begin
            s_reg <= s_next;
            if (cfg_wen)
            begin
                max_body_reg <= cfg_data;
            end
        end
    end

endmodule

// ----- dv/http_header_length_checker.sv -----
// Scoreboard for the HTTP header length scanner: watches the byte, result and register ports,
// predicts each result word from its own copy of the scan state, and compares field by field.
// Depends on hhls_pkg for the word types, status codes and scan phase codes.
module http_header_length_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  hhls_pkg::item_t   item,
    input  logic              pop,
    input  logic              empty,
    input  hhls_pkg::result_t result,
    input  logic              cfg_wen,
    input  logic [30:0]       cfg_data,
    output int                mismatch_count,
    output int                results_owed
);
    import hhls_pkg::*;

    localparam int MAX_HEADER    = 65535;
    localparam int VALUE_MAX_LEN = 31;

    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0b;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;

    localparam logic [8*14-1:0] LENGTH_KEY = "content-length";

    // scan state
    phase_t      line_ph;
    logic        first_line;
    logic        cr_pending;
    logic        line_fresh;
    int          name_pos;
    logic        name_bad;
    vphase_t     val_ph;
    int          val_len;
    logic [31:0] val_acc;
    logic        val_neg;
    logic        len_seen;
    logic        len_bad;
    logic [31:0] byte_cnt;
    logic        scan_done;
    status_t     verdict;
    logic [31:0] body_len;
    logic [30:0] max_body;

    result_t     header_results_due[$];

    function automatic logic is_space(logic [7:0] c);
        return c == CH_SP || c == CH_HT || c == CH_LF || c == CH_VT || c == CH_FF
            || c == CHAR_CR;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void restart_scan();
        line_ph    = PH_REQ;
        first_line = 1'b0;
        cr_pending = 1'b0;
        line_fresh = 1'b1;
        name_pos   = 0;
        name_bad   = 1'b0;
        val_ph     = VP_SKIP;
        val_len    = 0;
        val_acc    = '0;
        val_neg    = 1'b0;
        len_seen   = 1'b0;
        len_bad    = 1'b0;
        byte_cnt   = '0;
        scan_done  = 1'b0;
        verdict    = ST_OK;
        body_len   = '0;
    endfunction

    // decimal accumulate, pinned at 2^31 so it always fails the bound
    function automatic void add_digit(logic [7:0] c);
        logic [63:0] t;
        t = {32'd0, val_acc} * 64'd10 + {60'd0, c[3:0]};
        val_acc = (t > {32'd0, SAT_VALUE}) ? SAT_VALUE : t[31:0];
    endfunction

    function automatic void value_char(logic [7:0] c);
        if (val_ph == VP_SKIP)
        begin
            if (c == CH_SP || c == CH_HT)
                return;
            val_ph = VP_WS;
        end
        if (val_ph == VP_BAD)
            return;
        if (val_len >= VALUE_MAX_LEN)
        begin
            val_ph = VP_BAD;
            return;
        end
        val_len++;
        if (val_ph == VP_WS)
        begin
            if (is_space(c))
                return;
            if (c == CH_PLUS || c == CH_MINUS)
            begin
                val_neg = (c == CH_MINUS);
                val_ph  = VP_SIGN;
            end
            else if (is_digit(c))
            begin
                add_digit(c);
                val_ph = VP_DIGITS;
            end
            else
                val_ph = VP_BAD;
        end
        else if (is_digit(c))
        begin
            add_digit(c);
            val_ph = VP_DIGITS;
        end
        else
            val_ph = VP_BAD;
    endfunction

    function automatic void header_char(logic [7:0] c);
        logic [7:0] lc;
        line_fresh = 1'b0;
        case (line_ph)
            PH_NAME:
            begin
                if (c == CH_COLON)
                begin
                    if (!name_bad && name_pos == KEY_LEN && !len_seen)
                    begin
                        line_ph  = PH_VALUE;
                        val_ph   = VP_SKIP;
                        val_len  = 0;
                        val_acc  = '0;
                        val_neg  = 1'b0;
                        len_seen = 1'b1;
                    end
                    else
                        line_ph = PH_REST;
                end
                else
                begin
                    lc = (c >= CH_UP_A && c <= CH_UP_Z) ? c + 8'd32 : c;
                    if (name_pos < KEY_LEN && lc == LENGTH_KEY[8*(KEY_LEN-1-name_pos) +: 8])
                        name_pos++;
                    else
                        name_bad = 1'b1;
                end
            end
            PH_VALUE:
                value_char(c);
            default:
                ;
        endcase
    endfunction

    function automatic void close_value();
        if (val_ph == VP_DIGITS && !(val_neg && val_acc != 0) && val_acc <= {1'b0, max_body})
            body_len = val_acc;
        else
            len_bad = 1'b1;
    endfunction

    // CR LF seen; an empty line past the request line ends the header block
    function automatic void close_line();
        if (line_ph != PH_REQ && line_fresh)
        begin
            scan_done = 1'b1;
            if (first_line)
                len_bad = 1'b1;
            verdict = len_bad ? ST_INVALID : ST_OK;
            return;
        end
        if (line_ph == PH_VALUE)
            close_value();
        first_line = (line_ph == PH_REQ);
        line_ph    = PH_NAME;
        name_pos   = 0;
        name_bad   = 1'b0;
        line_fresh = 1'b1;
    endfunction

    function automatic void scan_byte(logic [7:0] b);
        if (cr_pending)
        begin
            cr_pending = 1'b0;
            if (b == CH_LF)
            begin
                close_line();
                return;
            end
            header_char(CHAR_CR);
        end
        if (b == CHAR_CR)
            cr_pending = 1'b1;
        else
            header_char(b);
    endfunction

    function automatic void absorb_word(item_t w);
        result_t r;
        logic    ok;
        if (!scan_done)
        begin
            if (w.data_byte == 8'h00)
            begin
                scan_done = 1'b1;
                verdict   = ST_INCOMPLETE;
            end
            else
            begin
                byte_cnt = byte_cnt + 1;
                scan_byte(w.data_byte);
                if (!scan_done && byte_cnt >= MAX_HEADER)
                begin
                    scan_done = 1'b1;
                    verdict   = ST_TOO_LONG;
                end
            end
        end
        if (w.last)
        begin
            r.status         = scan_done ? verdict : ST_INCOMPLETE;
            ok               = (r.status == ST_OK);
            r.header_size    = ok ? byte_cnt[15:0] : '0;
            r.content_length = ok ? body_len[30:0] : '0;
            header_results_due.push_back(r);
            restart_scan();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            mismatch_count = 0;
            max_body = MAX_BODY_RESET;
            restart_scan();
            header_results_due.delete();
        end
        else
        begin
            if (pop && !empty)
            begin
                if (header_results_due.size() == 0)
                    report_mismatch("word with none owed, status", 32'(result.status), 32'd0);
                else
                begin
                    want = header_results_due.pop_front();
                    if (result.status !== want.status)
                        report_mismatch("status", 32'(result.status), 32'(want.status));
                    if (result.header_size !== want.header_size)
                        report_mismatch("header_size", 32'(result.header_size),
                                        32'(want.header_size));
                    if (result.content_length !== want.content_length)
                        report_mismatch("content_length", 32'(result.content_length),
                                        32'(want.content_length));
                end
            end
            if (push && !full)
                absorb_word(item);
            if (cfg_wen)
                max_body = cfg_data;
        end
        results_owed = header_results_due.size();
    end

endmodule

// ----- dv/tb_http_header_length_scanner.sv -----
// Testbench top for the HTTP header length scanner: clock, reset, request byte stimulus,
// result drain with random stalls, register writes, watchdog and verdict.
// Depends on hhls_pkg, the scanner RTL and http_header_length_checker.
module tb_http_header_length_scanner;
    import hhls_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 6;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0b;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7a;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    item_t       item;
    logic        pop;
    logic        empty;
    result_t     result;
    logic        cfg_wen;
    logic [30:0] cfg_data;

    int          mismatches;
    int          owed;
    int          send_idle;
    int          recv_idle;
    int          holds_asked = 0;
    int          stall_cycles = 0;
    int          bytes_sent = 0;
    logic [30:0] cur_max;
    logic [7:0]  request_bytes[$];

    always #5 clk = ~clk;

    http_header_length_scanner dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .pop      (pop),
        .empty    (empty),
        .result   (result),
        .cfg_wen  (cfg_wen),
        .cfg_data (cfg_data)
    );

    http_header_length_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .item           (item),
        .pop            (pop),
        .empty          (empty),
        .result         (result),
        .cfg_wen        (cfg_wen),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatches),
        .results_owed   (owed)
    );

    // result side: random pops, or one long hold-off when asked
    initial
    begin
        int holds_served;
        holds_served = 0;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_asked != holds_served)
            begin
                holds_served = holds_asked;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic put_char(input logic [7:0] c);
        request_bytes.push_back(c);
    endtask

    task automatic put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            put_char(s[i]);
    endtask

    task automatic put_crlf();
        put_char(CHAR_CR);
        put_char(CH_LF);
    endtask

    task automatic put_number(input longint unsigned n);
        put_text($sformatf("%0d", n));
    endtask

    // push stays high across back-to-back words
    task automatic push_word(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= '{data_byte: b, last: fin};
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    task automatic send_buffer();
        int i;
        for (i = 0; i < request_bytes.size(); i++)
            push_word(request_bytes[i], i == request_bytes.size() - 1);
        bytes_sent += request_bytes.size();
        request_bytes.delete();
    endtask

    task automatic quiesce();
        push <= 1'b0;
        @(negedge clk);
        while (owed != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_body(input logic [30:0] v);
        quiesce();
        cfg_wen  <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_wen  <= 1'b0;
        cur_max = v;
    endtask

    task automatic put_length_header();
        string       name;
        int          i;
        int          k;
        logic [7:0]  ch;
        name = "Content-Length";
        for (i = 0; i < name.len(); i++)
        begin
            ch = name[i];
            if (ch >= CH_LO_A && ch <= CH_LO_Z && $urandom_range(1))
                ch = ch - 8'd32;
            else if (ch >= CH_UP_A && ch <= CH_UP_Z && $urandom_range(1))
                ch = ch + 8'd32;
            put_char(ch);
        end
        put_char(CH_COLON);
        repeat ($urandom_range(0, 2)) put_char($urandom_range(1) ? CH_SP : CH_HT);
        case ($urandom_range(0, 11))
            0: put_char(CH_VT);
            1: put_char(CH_FF);
            2: put_char(CH_LF);
            3: put_char(CHAR_CR);
            default: ;
        endcase
        case ($urandom_range(0, 5))
            0: put_char(CH_PLUS);
            1: put_char(CH_MINUS);
            default: ;
        endcase
        case ($urandom_range(0, 7))
            0: put_number(64'($urandom_range(0, 999)));
            1: put_number(64'(cur_max));
            2: put_number(64'(cur_max) + 64'd1);
            3: put_number(64'($urandom));
            4:
            begin
                k = $urandom_range(10, 34);
                repeat (k) put_char(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            5: put_char(CH_ZERO);
            6: ;
            default: put_number(64'(cur_max >> 1));
        endcase
        if ($urandom_range(0, 9) == 0)
            put_char(8'($urandom_range(8'h20, 8'h7e)));
    endtask

    task automatic put_other_header();
        case ($urandom_range(0, 5))
            0: put_text("Content-Lengt");
            1: put_text("Content-Lengthh");
            2: put_text("Content Length");
            3: put_text("X-Content-Length");
            default: repeat ($urandom_range(0, 6)) put_char(8'($urandom_range(8'h21, 8'h7e)));
        endcase
        if ($urandom_range(0, 7) != 0)
            put_char(CH_COLON);
        repeat ($urandom_range(0, 8)) put_char(8'($urandom_range(8'h20, 8'h7e)));
    endtask

    // mostly well-formed requests with random content and a few broken endings
    task automatic make_request();
        int n_hdr;
        n_hdr = $urandom_range(0, 4);
        repeat ($urandom_range(0, 6)) put_char(8'($urandom_range(8'h21, 8'h7e)));
        put_crlf();
        repeat (n_hdr)
        begin
            if ($urandom_range(0, 9) < 5)
                put_length_header();
            else
                put_other_header();
            put_crlf();
        end
        case ($urandom_range(0, 19))
            0: ;
            1:
            begin
                put_char(CH_NUL);
                put_crlf();
            end
            2: put_char(CHAR_CR);
            default: put_crlf();
        endcase
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) put_char(8'($urandom_range(0, 255)));
    endtask

    task automatic make_noise();
        repeat ($urandom_range(1, 12))
        begin
            case ($urandom_range(0, 15))
                0, 1, 2: put_char(CHAR_CR);
                3, 4, 5: put_char(CH_LF);
                6:       put_char(CH_NUL);
                default: put_char(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic run_random(input int target);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < target)
        begin
            if ($urandom_range(0, 9) == 0)
                make_noise();
            else
                make_request();
            send_buffer();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        push      = 1'b0;
        item      = '0;
        cfg_wen   = 1'b0;
        cfg_data  = '0;
        send_idle = 26;
        recv_idle = 85;
        cur_max   = MAX_BODY_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero byte ends the data at once; 0xff alone never finds the end
        put_char(CH_NUL);
        send_buffer();
        put_char(8'hff);
        send_buffer();
        // blank line right after the request line
        put_text("G");
        put_crlf();
        put_crlf();
        send_buffer();
        // minus zero, then body bytes that must be ignored
        put_text("G");
        put_crlf();
        put_text("Content-Length:-0");
        put_crlf();
        put_crlf();
        put_text("XY");
        send_buffer();

        write_max_body(31'h7fff_ffff);
        run_random(350);

        send_idle = 85;
        recv_idle = 26;
        write_max_body('0);
        run_random(175);
        write_max_body(31'($urandom_range(1, 5000)));
        run_random(175);

        send_idle = 0;
        recv_idle = 0;
        write_max_body(31'($urandom_range(0, 32'h7fff_ffff)));
        // fill the block while the result side holds off
        holds_asked++;
        repeat (30)
        begin
            make_noise();
            send_buffer();
        end
        run_random(300);

        write_max_body(MAX_BODY_RESET);

        quiesce();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
